// ===== hw/rtl/dupa_pkg.sv =====
// dupa_pkg: shared types and constants for the dmx universe pixel assembler
// item structs for the input and result channels, register indexes, sizes
// no dependencies
`timescale 1ns / 1ps

package dupa_pkg;

  localparam int LED_COUNT      = 512;
  localparam int UNIVERSE_COUNT = 4;
  localparam int UNI_IDX_W      = (UNIVERSE_COUNT > 1) ? $clog2(UNIVERSE_COUNT) : 1;

  localparam int UNIVERSE_W = 15;
  localparam int PLEN_W     = 10;
  localparam int SEQ_W      = 8;
  localparam int SLOT_W     = 7;
  localparam int COLOR_W    = 8;
  localparam int LED_IDX_W  = 9;
  localparam int MS_W       = 16;
  localparam int SLOTCNT_W  = PLEN_W - 2;
  localparam int PROD_W     = UNIVERSE_W + SLOTCNT_W;
  localparam int LED_SUM_W  = PROD_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_START_UNIVERSE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS     = CFG_IDX_W'(1);

  localparam logic [UNIVERSE_W-1:0] START_UNIVERSE_RST = UNIVERSE_W'(1);
  localparam logic [MS_W-1:0]       TIMEOUT_MS_RST     = MS_W'(1000);

  // sequence numbers this far behind the last good one or more count as fresh
  localparam logic [SEQ_W-1:0] STALE_WINDOW = SEQ_W'(200);

  localparam logic MODE_SLOT = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [UNIVERSE_W-1:0] universe;
    logic [PLEN_W-1:0]     packet_length;
    logic [SEQ_W-1:0]      sequence_req;
    logic [SLOT_W-1:0]     slot_index;
    logic                  slot_valid;
    logic [COLOR_W-1:0]    red_in;
    logic [COLOR_W-1:0]    green_in;
    logic [COLOR_W-1:0]    blue_in;
    logic [COLOR_W-1:0]    white_in;
    logic                  last_slot;
  } in_item_t;

  typedef struct packed {
    logic                 write_enable;
    logic [LED_IDX_W-1:0] led_index;
    logic [COLOR_W-1:0]   red_out;
    logic [COLOR_W-1:0]   green_out;
    logic [COLOR_W-1:0]   blue_out;
    logic [COLOR_W-1:0]   white_out;
    logic                 show_frame;
    logic                 link_alive;
  } out_item_t;

  typedef struct packed {
    logic [UNIVERSE_W-1:0] start_universe;
    logic [MS_W-1:0]       timeout_ms;
  } cfg_regs_t;

endpackage

// ===== hw/rtl/dupa_core.sv =====
// dupa_core: frame tracking state and per-item result logic
// holds seen set, last good sequence, previous length and ms counter
// depends on dupa_pkg
`timescale 1ns / 1ps

module dupa_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  dupa_pkg::in_item_t  item,
  input  dupa_pkg::cfg_regs_t cfg,
  output dupa_pkg::out_item_t res
);
  import dupa_pkg::*;

  logic [UNIVERSE_COUNT-1:0] seen_r, seen_nxt, seen_mark;
  logic [SEQ_W-1:0]          last_seq_r, last_seq_nxt;
  logic [PLEN_W-1:0]         prev_len_r, prev_len_nxt;
  logic [MS_W-1:0]           elapsed_r, elapsed_nxt;

  logic                  is_slot;
  logic                  above;
  logic [UNIVERSE_W-1:0] offs;
  logic [PROD_W-1:0]     prod;
  logic [LED_SUM_W-1:0]  led;
  logic                  in_packet;
  logic                  we;
  logic                  mark;
  logic [SEQ_W-1:0]      back;
  logic                  fresh;
  logic                  show;

  always_comb begin
    is_slot   = (item.mode == MODE_SLOT);
    above     = (item.universe >= cfg.start_universe);
    offs      = above ? (item.universe - cfg.start_universe) : '0;
    prod      = PROD_W'(offs) * PROD_W'(prev_len_r[PLEN_W-1:2]);
    led       = LED_SUM_W'(prod) + LED_SUM_W'(item.slot_index);
    in_packet = (SLOTCNT_W'(item.slot_index) < item.packet_length[PLEN_W-1:2]);
    we        = is_slot && item.slot_valid && above && in_packet
                && (led < LED_SUM_W'(LED_COUNT));

    mark      = above && (offs < UNIVERSE_W'(UNIVERSE_COUNT));
    seen_mark = seen_r;
    if (mark) begin
      seen_mark[offs[UNI_IDX_W-1:0]] = 1'b1;
    end
    back  = last_seq_r - item.sequence_req;
    fresh = !((item.sequence_req < last_seq_r) && (back < STALE_WINDOW));
    show  = is_slot && item.last_slot && (&seen_mark) && fresh;
  end

  always_comb begin
    seen_nxt     = seen_r;
    last_seq_nxt = last_seq_r;
    prev_len_nxt = prev_len_r;
    elapsed_nxt  = elapsed_r;
    if (!is_slot) begin
      if (elapsed_r != '1) begin
        elapsed_nxt = elapsed_r + MS_W'(1);
      end
    end else if (item.last_slot) begin
      seen_nxt     = show ? '0 : seen_mark;
      last_seq_nxt = fresh ? item.sequence_req : last_seq_r;
      prev_len_nxt = item.packet_length;
      if (show) begin
        elapsed_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      last_seq_r <= '0;
      prev_len_r <= '0;
      elapsed_r  <= '0;
    end else if (fire) begin
      seen_r     <= seen_nxt;
      last_seq_r <= last_seq_nxt;
      prev_len_r <= prev_len_nxt;
      elapsed_r  <= elapsed_nxt;
    end
  end

  always_comb begin
    res.write_enable = we;
    res.led_index    = we ? led[LED_IDX_W-1:0] : '0;
    res.red_out      = we ? item.red_in   : '0;
    res.green_out    = we ? item.green_in : '0;
    res.blue_out     = we ? item.blue_in  : '0;
    res.white_out    = we ? item.white_in : '0;
    res.show_frame   = show;
    res.link_alive   = (elapsed_nxt < cfg.timeout_ms);
  end

endmodule

// ===== hw/rtl/dmx_universe_pixel_assembler_unit.sv =====
// dmx_universe_pixel_assembler_unit: top level with input and result registers
// and the configuration registers; depends on dupa_pkg and dupa_core
// throughput: one item per cycle unless out_ready low stalls the result register,
// limited by the single state update in dupa_core
// reset: synchronous active-low; clears pipeline valids, seen set, sequence,
// length and ms counter, and loads start_universe 1 and timeout_ms 1000
`timescale 1ns / 1ps

module dmx_universe_pixel_assembler_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dupa_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dupa_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dupa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dupa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dupa_pkg::*;

  cfg_regs_t cfg_r;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      s1_adv;
  logic      fire;
  out_item_t core_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_universe <= START_UNIVERSE_RST;
      cfg_r.timeout_ms     <= TIMEOUT_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_UNIVERSE: cfg_r.start_universe <= cfg_data[UNIVERSE_W-1:0];
        REG_TIMEOUT_MS:     cfg_r.timeout_ms     <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv   = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= core_res;
    end
  end

  dupa_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  a_show_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && core_res.show_frame |-> s1_item_r.last_slot && (s1_item_r.mode == MODE_SLOT))
    else $error("show without a packet end");

  a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (s1_item_r.mode == MODE_TICK) |-> !core_res.write_enable && !core_res.show_frame)
    else $error("tick item wrote or showed");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && (out_item_r == $past(core_res)))
    else $error("result register not loaded");
`endif

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for dmx_universe_pixel_assembler_unit
// a scoreboard class predicts each result item in order and compares it field by field
// depends on dupa_pkg and the block rtl only
`timescale 1ns / 1ps

module tb_top;
  import dupa_pkg::*;

  class pixel_write_scoreboard;
    logic [UNIVERSE_W-1:0] start_uni;
    logic [MS_W-1:0]       timeout_lim;
    bit                    uni_seen[UNIVERSE_COUNT];
    logic [SEQ_W-1:0]      good_seq;
    logic [PLEN_W-1:0]     prior_len;
    logic [MS_W-1:0]       ms_count;
    out_item_t             pending_writes[$];
    int                    errors;

    function new();
      start_uni   = START_UNIVERSE_RST;
      timeout_lim = TIMEOUT_MS_RST;
      foreach (uni_seen[k]) uni_seen[k] = 1'b0;
      good_seq  = '0;
      prior_len = '0;
      ms_count  = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_START_UNIVERSE: start_uni = data[UNIVERSE_W-1:0];
        REG_TIMEOUT_MS:     timeout_lim = data[MS_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(in_item_t it);
      out_item_t        exp;
      bit               above;
      bit               all_in;
      bit               fresh;
      int unsigned      offs;
      int unsigned      led;
      logic [SEQ_W-1:0] back;
      exp = '0;
      if (it.mode == MODE_TICK) begin
        if (ms_count != '1) ms_count = ms_count + 1'b1;
      end else begin
        above = (it.universe >= start_uni);
        offs  = above ? (32'(it.universe) - 32'(start_uni)) : 0;
        if (it.slot_valid && above && (32'(it.slot_index) < 32'(it.packet_length) / 4)) begin
          led = 32'(it.slot_index) + offs * (32'(prior_len) / 4);
          if (led < LED_COUNT) begin
            exp.write_enable = 1'b1;
            exp.led_index    = led[LED_IDX_W-1:0];
            exp.red_out      = it.red_in;
            exp.green_out    = it.green_in;
            exp.blue_out     = it.blue_in;
            exp.white_out    = it.white_in;
          end
        end
        if (it.last_slot) begin
          if (above && offs < UNIVERSE_COUNT) uni_seen[offs] = 1'b1;
          all_in = 1'b1;
          foreach (uni_seen[k]) if (!uni_seen[k]) all_in = 1'b0;
          back  = good_seq - it.sequence_req;
          fresh = !(it.sequence_req < good_seq && back < STALE_WINDOW);
          if (fresh) good_seq = it.sequence_req;
          exp.show_frame = all_in && fresh;
          prior_len = it.packet_length;
          if (exp.show_frame) begin
            foreach (uni_seen[k]) uni_seen[k] = 1'b0;
            ms_count = '0;
          end
        end
      end
      exp.link_alive = (ms_count < timeout_lim);
      pending_writes.push_back(exp);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_write(out_item_t got);
      out_item_t exp;
      if (pending_writes.size() == 0) begin
        $display("%0t unexpected result item: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp = pending_writes.pop_front();
      compare_field("write_enable", exp.write_enable, got.write_enable);
      compare_field("led_index", exp.led_index, got.led_index);
      compare_field("red_out", exp.red_out, got.red_out);
      compare_field("green_out", exp.green_out, got.green_out);
      compare_field("blue_out", exp.blue_out, got.blue_out);
      compare_field("white_out", exp.white_out, got.white_out);
      compare_field("show_frame", exp.show_frame, got.show_frame);
      compare_field("link_alive", exp.link_alive, got.link_alive);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_write_scoreboard sb;
  bit                    no_idle;
  int                    sent_count;
  logic [SEQ_W-1:0]      seq_ctr;

  dmx_universe_pixel_assembler_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  function automatic in_item_t slot_item(int unsigned uni, int unsigned plen, int unsigned seq,
                                         int unsigned slot, bit sv, bit last);
    in_item_t it;
    it = '0;
    it.mode          = MODE_SLOT;
    it.universe      = uni[UNIVERSE_W-1:0];
    it.packet_length = plen[PLEN_W-1:0];
    it.sequence_req  = seq[SEQ_W-1:0];
    it.slot_index    = slot[SLOT_W-1:0];
    it.slot_valid    = sv;
    it.red_in        = COLOR_W'($urandom());
    it.green_in      = COLOR_W'($urandom());
    it.blue_in       = COLOR_W'($urandom());
    it.white_in      = COLOR_W'($urandom());
    it.last_slot     = last;
    return it;
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    it = raw[$bits(in_item_t)-1:0];
    it.mode = MODE_TICK;
    it.packet_length = PLEN_W'($urandom_range(0, 512));
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_item(it);
    sent_count++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one frame: a packet per universe in random order, some aimed outside the range, mostly in sequence
  task automatic send_frame();
    int unsigned order[UNIVERSE_COUNT];
    int unsigned plen;
    int unsigned uni;
    int unsigned seq;
    int unsigned nslots;
    int unsigned tmp;
    int unsigned j;
    foreach (order[k]) order[k] = k;
    for (int k = 0; k < UNIVERSE_COUNT; k++) begin
      j = $urandom_range(k, UNIVERSE_COUNT - 1);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 512) : 4 * $urandom_range(1, 8);
    no_idle = ($urandom_range(0, 4) == 0);
    for (int k = 0; k < UNIVERSE_COUNT; k++) begin
      if ($urandom_range(0, 5) == 0) plen = $urandom_range(0, 512);
      case ($urandom_range(0, 11))
        0:       uni = sb.start_uni - 1;
        1:       uni = sb.start_uni + UNIVERSE_COUNT + $urandom_range(0, 3);
        default: uni = sb.start_uni + order[k];
      endcase
      if ($urandom_range(0, 9) == 0) begin
        seq = seq_ctr - $urandom_range(1, 199);
      end else begin
        seq_ctr = seq_ctr + 1'b1;
        seq = seq_ctr;
      end
      nslots = plen / 4;
      if (nslots > 6) nslots = $urandom_range(1, 6);
      if (nslots == 0) begin
        send_item(slot_item(uni, plen, seq, $urandom_range(0, 127), 1'b0, 1'b1));
      end else begin
        for (int s = 0; s < nslots; s++) begin
          send_item(slot_item(uni, plen, seq, s, 1'b1, s == nslots - 1));
        end
      end
      if ($urandom_range(0, 9) == 0) send_item(tick_item());
    end
  endtask

  task automatic random_traffic(int n);
    int target;
    int pick;
    in_item_t it;
    logic [95:0] raw;
    target = sent_count + n;
    while (sent_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame();
      end else if (pick < 85) begin
        no_idle = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 20)) send_item(tick_item());
      end else if (pick < 98) begin
        raw = {$urandom(), $urandom(), $urandom()};
        it = raw[$bits(in_item_t)-1:0];
        it.packet_length = PLEN_W'($urandom_range(0, 512));
        if ($urandom_range(0, 3) != 0) it.mode = MODE_SLOT;
        send_item(it);
      end else begin
        drain();
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_write(out_item);
    end
  end

  initial begin : stimulus
    in_item_t    directed[$];
    int unsigned phase_start[6];
    int unsigned phase_timeout[6];
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_START_UNIVERSE;
    cfg_data   = '0;
    no_idle    = 1'b0;
    sent_count = 0;
    seq_ctr    = '0;
    sb = new();
    phase_start   = '{0, 32767, 5, 1000, 1, 0};
    phase_timeout = '{1, 65535, 0, 20, 3, 0};
    phase_start[5]   = $urandom_range(0, 200);
    phase_timeout[5] = $urandom_range(1, 40);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed.push_back(tick_item());
    directed.push_back(slot_item(0, 16, 1, 0, 1'b1, 1'b1));
    directed.push_back(slot_item(1, 512, 2, 127, 1'b1, 1'b0));
    directed[2].red_in   = '1;
    directed[2].green_in = '1;
    directed[2].blue_in  = '1;
    directed[2].white_in = '1;
    directed.push_back(slot_item(1, 512, 2, 0, 1'b1, 1'b1));
    directed[3].red_in   = '0;
    directed[3].green_in = '0;
    directed[3].blue_in  = '0;
    directed[3].white_in = '0;
    directed.push_back(slot_item(2, 8, 3, 2, 1'b1, 1'b0));
    directed.push_back(slot_item(2, 8, 3, 1, 1'b0, 1'b1));
    directed.push_back(slot_item(3, 8, 4, 1, 1'b1, 1'b1));
    directed.push_back(slot_item(4, 8, 5, 0, 1'b1, 1'b1));
    directed.push_back(slot_item(5, 8, 6, 1, 1'b1, 1'b0));
    directed.push_back(slot_item(32767, 8, 6, 0, 1'b1, 1'b1));
    directed.push_back(slot_item(1, 0, 5, 0, 1'b0, 1'b1));
    directed.push_back(slot_item(1, 4, 250, 0, 1'b1, 1'b1));
    directed.push_back(slot_item(2, 4, 2, 0, 1'b1, 1'b1));
    directed.push_back(slot_item(3, 4, 51, 0, 1'b1, 1'b1));
    directed.push_back(slot_item(4, 4, 0, 0, 1'b1, 1'b1));
    directed.push_back(slot_item(4, 4, 255, 0, 1'b1, 1'b1));
    directed.push_back(tick_item());
    directed.push_back(slot_item(0, 512, 255, 127, 1'b1, 1'b0));
    foreach (directed[k]) send_item(directed[k]);
    seq_ctr = 8'd255;
    drain();

    foreach (phase_start[p]) begin
      cfg_write(REG_START_UNIVERSE, CFG_DATA_W'(phase_start[p]));
      cfg_write(REG_TIMEOUT_MS, CFG_DATA_W'(phase_timeout[p]));
      random_traffic(250);
      drain();
    end

    // a long run of ticks past a short timeout
    cfg_write(REG_START_UNIVERSE, CFG_DATA_W'(0));
    cfg_write(REG_TIMEOUT_MS, CFG_DATA_W'(30));
    no_idle = 1'b1;
    repeat (40) send_item(tick_item());
    no_idle = 1'b0;
    random_traffic(80);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dupa_pkg.sv
hw/rtl/dupa_core.sv
hw/rtl/dmx_universe_pixel_assembler_unit.sv
dv/tb_top.sv
